// ===== hdl/hsv2rgb_pkg.sv =====
// Shared widths, constants and codes for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW   = 11;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SecW   = 3;
  localparam int unsigned ProdW  = 16;  // f*s, (256-f)*s, v*(255-s)
  localparam int unsigned NumW   = 17;  // pre-divide numerators, all below 510*256
  localparam int unsigned LaneW  = 2;

  localparam int unsigned SectorSteps = 256;
  localparam int unsigned FullScale   = 255;
  localparam int unsigned FracScale   = SectorSteps * FullScale;  // 65280
  localparam int unsigned NumSectors  = 6;

  // Division by 510: multiply by 257, shift by 17, then one correction step.
  localparam int unsigned DivConst   = 2 * FullScale;
  localparam int unsigned RecipMul   = 257;
  localparam int unsigned RecipShift = 17;

  // Lanes of the shared divide stages.
  localparam int unsigned NumLanes = 3;
  localparam logic [LaneW-1:0] LaneP = 2'd0;
  localparam logic [LaneW-1:0] LaneQ = 2'd1;
  localparam logic [LaneW-1:0] LaneT = 2'd2;

  // Hue sectors, sixty degrees each.
  localparam logic [SecW-1:0] SecRedYellow   = 3'd0;
  localparam logic [SecW-1:0] SecYellowGreen = 3'd1;
  localparam logic [SecW-1:0] SecGreenCyan   = 3'd2;
  localparam logic [SecW-1:0] SecCyanBlue    = 3'd3;
  localparam logic [SecW-1:0] SecBlueMagenta = 3'd4;
  localparam logic [SecW-1:0] SecMagentaRed  = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter.sv =====
// Five-stage pipelined HSV to RGB pixel converter.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_ready_o | hue_i[10:0] saturation_i brightness_i
//   out     | source    | out_valid_o / out_ready_i | red_o green_o blue_o
//
// Each input passes stages 1 to 5 to output valid; one pixel per clock is sustained
// unless the output stalls. The depth is set by the two multiplier stages (the
// products, then v times the scaled term) and the two-step divide by 510.
// Reset clears only the stage valid bits; data registers carry no reset.
// Each stage has its own ready (empty or next stage ready), so a stall at
// the output backs up one stage at a time and bubbles are squeezed out.
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire  [HueW-1:0]  hue_i,
  input  wire  [ChanW-1:0] saturation_i,
  input  wire  [ChanW-1:0] brightness_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  // ---------------------------------------------------------------------
  // Stage valids and the per-stage ready chain
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v5_q;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;
  assign v5_d = rdy5 ? v4_q : v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: sector wrap and the three 16-bit products
  // ---------------------------------------------------------------------
  logic [SecW-1:0]  sec_raw, s1_sec_d, s1_sec_q;
  logic [ChanW-1:0] frac, s1_v_q;
  logic [ChanW:0]   frac_inv;     // 256 - f, up to 256
  logic [ProdW-1:0] s1_fs_d, s1_gs_d, s1_vps_d;
  logic [ProdW-1:0] s1_fs_q, s1_gs_q, s1_vps_q;
  logic [ProdW:0]   gs_full;

  always_comb begin
    sec_raw  = hue_i[HueW-1:HueW-SecW];
    frac     = hue_i[ChanW-1:0];
    // hue beyond 1535 lands in sectors 6 and 7, which fold onto 0 and 1
    s1_sec_d = (sec_raw >= SecW'(NumSectors)) ? sec_raw - SecW'(NumSectors) : sec_raw;
    frac_inv = (ChanW+1)'(SectorSteps) - {1'b0, frac};
    s1_fs_d  = frac * saturation_i;
    gs_full  = frac_inv * {1'b0, saturation_i};
    s1_gs_d  = gs_full[ProdW-1:0];   // at most 256*255, fits
    s1_vps_d = brightness_i * (ChanW'(FullScale) - saturation_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_sec_q <= s1_sec_d;
      s1_v_q   <= brightness_i;
      s1_fs_q  <= s1_fs_d;
      s1_gs_q  <= s1_gs_d;
      s1_vps_q <= s1_vps_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: numerators. For q and t the divide by 65280 is split into
  // a shift by 7 (exact, since the rounding offset is 255*128) and a
  // divide by 510 shared with p.
  // ---------------------------------------------------------------------
  logic [NumW-1:0]  m2_d [NumLanes];
  logic [NumW-1:0]  m2_q [NumLanes];
  logic [SecW-1:0]  s2_sec_q;
  logic [ChanW-1:0] s2_v_q;
  logic [ProdW-1:0] xq, xt;
  logic [ChanW+ProdW-1:0] vxq, vxt;
  logic [NumW:0]    mq_full, mt_full, mp_full;

  always_comb begin
    xq      = ProdW'(FracScale) - s1_fs_q;
    xt      = ProdW'(FracScale) - s1_gs_q;
    vxq     = s1_v_q * xq;
    vxt     = s1_v_q * xt;
    mp_full = {1'b0, s1_vps_q, 1'b0} + (NumW+1)'(FullScale);
    mq_full = {1'b0, vxq[ChanW+ProdW-1:7]} + (NumW+1)'(FullScale);
    mt_full = {1'b0, vxt[ChanW+ProdW-1:7]} + (NumW+1)'(FullScale);
    m2_d[LaneP] = mp_full[NumW-1:0];
    m2_d[LaneQ] = mq_full[NumW-1:0];
    m2_d[LaneT] = mt_full[NumW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      m2_q     <= m2_d;
      s2_sec_q <= s1_sec_q;
      s2_v_q   <= s1_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: quotient estimate by reciprocal, never above the true value
  // and at most one below it
  // ---------------------------------------------------------------------
  logic [ChanW-1:0] est3_d [NumLanes];
  logic [ChanW-1:0] est3_q [NumLanes];
  logic [NumW-1:0]  m3_q   [NumLanes];
  logic [SecW-1:0]  s3_sec_q;
  logic [ChanW-1:0] s3_v_q;
  logic [NumW+8:0]  recip_prod [NumLanes];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      recip_prod[i] = m2_q[i] * 9'(RecipMul);
      est3_d[i]     = recip_prod[i][RecipShift+ChanW-1:RecipShift];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      est3_q   <= est3_d;
      m3_q     <= m2_q;
      s3_sec_q <= s2_sec_q;
      s3_v_q   <= s2_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: remainder check and correction
  // ---------------------------------------------------------------------
  logic [ChanW-1:0] res4_d [NumLanes];
  logic [ChanW-1:0] res4_q [NumLanes];
  logic [SecW-1:0]  s4_sec_q;
  logic [ChanW-1:0] s4_v_q;
  logic [NumW-1:0]  back [NumLanes];
  logic [NumW-1:0]  rem  [NumLanes];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      back[i]   = {{(NumW-ChanW){1'b0}}, est3_q[i]} * NumW'(DivConst);
      rem[i]    = m3_q[i] - back[i];
      res4_d[i] = (rem[i] >= NumW'(DivConst)) ? est3_q[i] + 1'b1 : est3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      res4_q   <= res4_d;
      s4_sec_q <= s3_sec_q;
      s4_v_q   <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sector ordering into the output register
  // ---------------------------------------------------------------------
  logic [ChanW-1:0] r_d, g_d, b_d;
  logic [ChanW-1:0] r_q, g_q, b_q;
  logic [ChanW-1:0] pv, qv, tv;

  always_comb begin
    pv = res4_q[LaneP];
    qv = res4_q[LaneQ];
    tv = res4_q[LaneT];
    case (s4_sec_q)
      SecRedYellow: begin
        r_d = s4_v_q; g_d = tv; b_d = pv;
      end
      SecYellowGreen: begin
        r_d = qv; g_d = s4_v_q; b_d = pv;
      end
      SecGreenCyan: begin
        r_d = pv; g_d = s4_v_q; b_d = tv;
      end
      SecCyanBlue: begin
        r_d = pv; g_d = qv; b_d = s4_v_q;
      end
      SecBlueMagenta: begin
        r_d = tv; g_d = pv; b_d = s4_v_q;
      end
      SecMagentaRed: begin
        r_d = s4_v_q; g_d = pv; b_d = qv;
      end
      default: begin
        r_d = s4_v_q; g_d = pv; b_d = qv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign red_o   = r_q;
  assign green_o = g_q;
  assign blue_o  = b_q;

endmodule

`default_nettype wire

// ===== hdl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
`default_nettype none

module hsv2rgb_props
  import hsv2rgb_pkg::*;
(
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_ready_o,
  input wire [HueW-1:0]  hue_i,
  input wire [ChanW-1:0] saturation_i,
  input wire [ChanW-1:0] brightness_i,
  input wire             out_valid_o,
  input wire             out_ready_i,
  input wire [ChanW-1:0] red_o,
  input wire [ChanW-1:0] green_o,
  input wire [ChanW-1:0] blue_o
);

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(hue_i) &&
      $stable(saturation_i) && $stable(brightness_i))
    else $error("input changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) &&
      $stable(green_o) && $stable(blue_o))
    else $error("output changed while stalled");

  // free output slot means the whole pipe can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output free");

  // an accepted transaction reaches output valid when the output never stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_o, 5) &&
    $past(out_ready_i, 1) && $past(out_ready_i, 2) &&
    $past(out_ready_i, 3) && $past(out_ready_i, 4) &&
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
    $past(rst_ni, 4) && $past(rst_ni, 5)
    |-> out_valid_o)
    else $error("transaction did not arrive after five cycles");

endmodule

bind hsv_to_rgb_converter hsv2rgb_props u_hsv2rgb_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .hue_i        (hue_i),
  .saturation_i (saturation_i),
  .brightness_i (brightness_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o)
);

`default_nettype wire
